/* rtl/irc_line_tokenizer_macros.svh */
// Assertion helpers used by the tokenizer RTL top level.
`ifndef IRC_LINE_TOKENIZER_MACROS_SVH
`define IRC_LINE_TOKENIZER_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define IRC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the next cycle.
`define IRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/irclt_pkg.sv */
package irclt_pkg;

  localparam int unsigned PC_W            = 4;
  localparam logic [PC_W-1:0] MAX_PARAM_INDEX = 4'd15;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  localparam logic [1:0] KIND_PREFIX = 2'd0;
  localparam logic [1:0] KIND_CMD    = 2'd1;
  localparam logic [1:0] KIND_MIDDLE = 2'd2;
  localparam logic [1:0] KIND_TRAIL  = 2'd3;

  typedef enum logic [2:0] {
    PH_START,
    PH_PREFIX,
    PH_CMD,
    PH_PSTART,
    PH_MIDDLE,
    PH_TRAIL
  } phase_t;

  typedef struct packed {
    logic [7:0]      token_byte;
    logic            has_byte;
    logic [1:0]      field_kind;
    logic [PC_W-1:0] param_index;
    logic            token_end;
    logic            line_done;
    logic            last_of_step;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } step_out_t;

  function automatic res_t mk_res(logic [7:0] b, logic has, logic [1:0] kind,
                                  logic tend, logic done, logic [PC_W-1:0] pc);
    res_t r;
    r.token_byte   = b;
    r.has_byte     = has;
    r.field_kind   = kind;
    r.param_index  = (kind == KIND_MIDDLE || kind == KIND_TRAIL) ? pc : '0;
    r.token_end    = tend;
    r.line_done    = done;
    r.last_of_step = 1'b0;
    return r;
  endfunction

  function automatic res_t done_only();
    return mk_res(8'd0, 1'b0, KIND_PREFIX, 1'b0, 1'b1, '0);
  endfunction

endpackage

/* rtl/irc_line_tokenizer.sv */
// Accepted bytes are held in the input stage and parsed once the result queue has room.
// Throughput: one input byte per cycle while the queue holds two results or fewer; a byte
// yielding two results takes two entries; the 4-entry result queue absorbs the burst.
// Rate is set by the single-pass parse step and the one-result-per-cycle output port.
// Reset (rst_n low, synchronous): parser back to line start, holdback and
// parameter count cleared, input stage and result queue emptied.
`include "irc_line_tokenizer_macros.svh"

module irc_line_tokenizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // line_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] token_byte, [11:8] param_index, [15:12] zero
  output logic [4:0]  out_tuser,  // [0] has_byte, [2:1] field_kind, [3] token_end,
                                  // [4] last_of_step
  output logic        out_tlast   // line_done
);

  logic                 stg_v_r;
  logic [7:0]           stg_byte_r;
  logic                 stg_end_r;
  logic                 fire;

  irclt_pkg::step_out_t step;

  irclt_pkg::res_t      fifo_r [4];
  logic [1:0]           head_r, tail_r;
  logic [2:0]           cnt_r;
  logic                 pop;
  irclt_pkg::res_t      head_res;

  assign fire      = stg_v_r && cnt_r <= 3'd2;
  assign in_tready = !stg_v_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else if (in_tready) begin
      stg_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      stg_byte_r <= in_tdata;
      stg_end_r  <= in_tlast;
    end
  end

  irclt_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .in_byte (stg_byte_r),
    .in_end  (stg_end_r),
    .step_o  (step)
  );

  assign pop      = out_tvalid && out_tready;
  assign head_res = fifo_r[head_r];

  always_ff @(posedge clk) begin
    if (step.cnt != 2'd0) begin
      fifo_r[tail_r] <= step.r0;
    end
    if (step.cnt == 2'd2) begin
      fifo_r[tail_r + 2'd1] <= step.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= 2'd0;
      tail_r <= 2'd0;
      cnt_r  <= 3'd0;
    end else begin
      head_r <= head_r + {1'b0, pop};
      tail_r <= tail_r + step.cnt;
      cnt_r  <= cnt_r + {1'b0, step.cnt} - {2'b00, pop};
    end
  end

  assign out_tvalid = cnt_r != 3'd0;
  assign out_tdata  = {4'd0, head_res.param_index, head_res.token_byte};
  assign out_tuser  = {head_res.last_of_step, head_res.token_end, head_res.field_kind,
                       head_res.has_byte};
  assign out_tlast  = head_res.line_done;

  `IRC_ASSERT_NOW(a_queue_bound, 1'b1, cnt_r <= 3'd4, "result queue overflow")
  `IRC_ASSERT_NOW(a_line_end_done, fire && stg_end_r,
    (step.cnt == 2'd1 && step.r0.line_done) || (step.cnt == 2'd2 && step.r1.line_done),
    "line end did not produce a line_done result")
  `IRC_ASSERT_NOW(a_done_is_last, out_tvalid && out_tlast, out_tuser[4],
    "line_done result not last of its step")
  `IRC_ASSERT_NEXT(a_push_count, fire && !pop && cnt_r == 3'd0,
    cnt_r == {1'b0, $past(step.cnt)}, "queue count mismatch after push")

endmodule

/* rtl/irclt_parse.sv */
module irclt_parse (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  logic [7:0]           in_byte,
  input  logic                 in_end,
  output irclt_pkg::step_out_t step_o
);

  irclt_pkg::phase_t           ph_r, ph_nxt;
  logic [7:0]                  hb_r, hb_nxt;
  logic                        hv_r, hv_nxt;
  logic [1:0]                  hk_r, hk_nxt;
  logic [irclt_pkg::PC_W-1:0]  pc_r, pc_nxt;
  logic                        th_r, th_nxt;

  logic                        crlf;
  logic                        do_put, do_close, do_bump;
  logic [1:0]                  put_kind, close_kind;
  logic                        s_v;
  irclt_pkg::res_t             s_res, f_res;

  function automatic logic in_token(irclt_pkg::phase_t p);
    return p == irclt_pkg::PH_PREFIX || p == irclt_pkg::PH_CMD ||
           p == irclt_pkg::PH_MIDDLE || p == irclt_pkg::PH_TRAIL;
  endfunction

  function automatic irclt_pkg::res_t fin(irclt_pkg::phase_t p, logic hv, logic [7:0] hb,
                                          logic [1:0] hk, logic [irclt_pkg::PC_W-1:0] pc,
                                          logic th);
    irclt_pkg::res_t r;
    r = irclt_pkg::done_only();
    if (in_token(p) && hv) begin
      r = irclt_pkg::mk_res(hb, 1'b1, hk, 1'b1, 1'b1, pc);
    end else begin
      unique case (p)
        irclt_pkg::PH_PREFIX: begin
          r = irclt_pkg::mk_res(8'd0, 1'b0, irclt_pkg::KIND_PREFIX, 1'b1, 1'b1, pc);
        end
        irclt_pkg::PH_CMD: begin
          r = irclt_pkg::mk_res(8'd0, 1'b0, irclt_pkg::KIND_CMD, 1'b1, 1'b1, pc);
        end
        irclt_pkg::PH_MIDDLE: begin
          if (th || pc != '0) begin
            r = irclt_pkg::mk_res(8'd0, 1'b0, irclt_pkg::KIND_MIDDLE, 1'b1, 1'b1, pc);
          end
        end
        irclt_pkg::PH_TRAIL: begin
          if (th) begin
            r = irclt_pkg::mk_res(8'd0, 1'b0, irclt_pkg::KIND_TRAIL, 1'b1, 1'b1, pc);
          end
        end
        irclt_pkg::PH_PSTART: begin
          if (pc != '0) begin
            r = irclt_pkg::mk_res(8'd0, 1'b0, irclt_pkg::KIND_MIDDLE, 1'b1, 1'b1, pc);
          end
        end
        default: begin
          r = irclt_pkg::done_only();
        end
      endcase
    end
    r.last_of_step = 1'b1;
    return r;
  endfunction

  // next state
  always_comb begin
    ph_nxt     = ph_r;
    hb_nxt     = hb_r;
    hv_nxt     = hv_r;
    hk_nxt     = hk_r;
    pc_nxt     = pc_r;
    th_nxt     = th_r;
    do_put     = 1'b0;
    do_close   = 1'b0;
    do_bump    = 1'b0;
    put_kind   = irclt_pkg::KIND_PREFIX;
    close_kind = irclt_pkg::KIND_PREFIX;
    s_v        = 1'b0;
    s_res      = '0;

    crlf = in_end && in_byte == irclt_pkg::CH_LF && hv_r &&
           hb_r == irclt_pkg::CH_CR && in_token(ph_r);

    if (crlf) begin
      hv_nxt = 1'b0;
    end else begin
      unique case (ph_r)
        irclt_pkg::PH_PREFIX: begin
          if (in_byte == irclt_pkg::CH_SPACE) begin
            do_close   = 1'b1;
            close_kind = irclt_pkg::KIND_PREFIX;
            ph_nxt     = irclt_pkg::PH_CMD;
          end else begin
            do_put   = 1'b1;
            put_kind = irclt_pkg::KIND_PREFIX;
          end
        end
        irclt_pkg::PH_CMD: begin
          if (in_byte == irclt_pkg::CH_SPACE) begin
            do_close   = 1'b1;
            close_kind = irclt_pkg::KIND_CMD;
            ph_nxt     = irclt_pkg::PH_PSTART;
          end else begin
            do_put   = 1'b1;
            put_kind = irclt_pkg::KIND_CMD;
          end
        end
        irclt_pkg::PH_PSTART: begin
          if (in_byte == irclt_pkg::CH_SPACE) begin
            s_v     = 1'b1;
            s_res   = irclt_pkg::mk_res(8'd0, 1'b0, irclt_pkg::KIND_MIDDLE, 1'b1, 1'b0,
                                        pc_r);
            do_bump = 1'b1;
          end else if (in_byte == irclt_pkg::CH_COLON) begin
            ph_nxt = irclt_pkg::PH_TRAIL;
            th_nxt = 1'b0;
          end else begin
            ph_nxt   = irclt_pkg::PH_MIDDLE;
            th_nxt   = 1'b0;
            do_put   = 1'b1;
            put_kind = irclt_pkg::KIND_MIDDLE;
          end
        end
        irclt_pkg::PH_MIDDLE: begin
          if (in_byte == irclt_pkg::CH_SPACE) begin
            do_close   = 1'b1;
            close_kind = irclt_pkg::KIND_MIDDLE;
            do_bump    = 1'b1;
            ph_nxt     = irclt_pkg::PH_PSTART;
          end else begin
            do_put   = 1'b1;
            put_kind = irclt_pkg::KIND_MIDDLE;
          end
        end
        irclt_pkg::PH_TRAIL: begin
          do_put   = 1'b1;
          put_kind = irclt_pkg::KIND_TRAIL;
        end
        default: begin
          hv_nxt = 1'b0;
          th_nxt = 1'b0;
          pc_nxt = '0;
          if (in_byte == irclt_pkg::CH_COLON) begin
            ph_nxt = irclt_pkg::PH_PREFIX;
          end else if (in_byte == irclt_pkg::CH_SPACE) begin
            s_v    = 1'b1;
            s_res  = irclt_pkg::mk_res(8'd0, 1'b0, irclt_pkg::KIND_CMD, 1'b1, 1'b0, '0);
            ph_nxt = irclt_pkg::PH_PSTART;
          end else begin
            ph_nxt   = irclt_pkg::PH_CMD;
            do_put   = 1'b1;
            put_kind = irclt_pkg::KIND_CMD;
          end
        end
      endcase
    end

    // release the held byte, hold the new one
    if (do_put) begin
      if (hv_nxt) begin
        s_v    = 1'b1;
        s_res  = irclt_pkg::mk_res(hb_nxt, 1'b1, hk_nxt, 1'b0, 1'b0, pc_nxt);
        th_nxt = 1'b1;
      end
      hb_nxt = in_byte;
      hv_nxt = 1'b1;
      hk_nxt = put_kind;
    end

    if (do_close) begin
      s_v = 1'b1;
      if (hv_nxt) begin
        s_res = irclt_pkg::mk_res(hb_nxt, 1'b1, hk_nxt, 1'b1, 1'b0, pc_nxt);
      end else begin
        s_res = irclt_pkg::mk_res(8'd0, 1'b0, close_kind, 1'b1, 1'b0, pc_nxt);
      end
      hv_nxt = 1'b0;
      th_nxt = 1'b0;
    end

    if (do_bump && pc_nxt < irclt_pkg::MAX_PARAM_INDEX) begin
      pc_nxt = pc_nxt + {{(irclt_pkg::PC_W-1){1'b0}}, 1'b1};
    end

    s_res.last_of_step = !in_end;
    f_res = fin(ph_nxt, hv_nxt, hb_nxt, hk_nxt, pc_nxt, th_nxt);

    if (in_end) begin
      ph_nxt = irclt_pkg::PH_START;
      hb_nxt = 8'd0;
      hv_nxt = 1'b0;
      hk_nxt = irclt_pkg::KIND_PREFIX;
      pc_nxt = '0;
      th_nxt = 1'b0;
    end
  end

  // outputs
  always_comb begin
    step_o.cnt = fire ? ({1'b0, s_v} + {1'b0, in_end}) : 2'd0;
    step_o.r0  = s_v ? s_res : f_res;
    step_o.r1  = f_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= irclt_pkg::PH_START;
      hb_r <= 8'd0;
      hv_r <= 1'b0;
      hk_r <= irclt_pkg::KIND_PREFIX;
      pc_r <= '0;
      th_r <= 1'b0;
    end else if (fire) begin
      ph_r <= ph_nxt;
      hb_r <= hb_nxt;
      hv_r <= hv_nxt;
      hk_r <= hk_nxt;
      pc_r <= pc_nxt;
      th_r <= th_nxt;
    end
  end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [4:0]  out_tuser;
  logic        out_tlast;

  irc_line_tokenizer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // tokenizer state mirrored by the predictor
  irclt_pkg::phase_t          tok_phase = irclt_pkg::PH_START;
  logic [7:0]                 hold_byte = 8'd0;
  logic                       hold_valid = 1'b0;
  logic [1:0]                 hold_kind = 2'd0;
  logic [irclt_pkg::PC_W-1:0] param_num = '0;
  logic                       token_started = 1'b0;
  irclt_pkg::res_t            step_res [2];
  int                         step_cnt;

  irclt_pkg::res_t expected_tokens [$];
  logic [7:0]      line_buf [$];
  int              send_idle_pct = 0;
  int              recv_idle_pct = 0;
  int              errors = 0;
  int              bytes_sent = 0;
  int              lines_sent = 0;
  int              results_seen = 0;
  int              markers_seen = 0;
  int              saturated_seen = 0;

  function automatic void emit_token(logic [7:0] b, logic has, logic [1:0] kind,
                                     logic tend, logic done);
    irclt_pkg::res_t r;
    if (step_cnt < 2) begin
      r.token_byte   = b;
      r.has_byte     = has;
      r.field_kind   = kind;
      r.param_index  = (kind == irclt_pkg::KIND_MIDDLE || kind == irclt_pkg::KIND_TRAIL) ?
                       param_num : '0;
      r.token_end    = tend;
      r.line_done    = done;
      r.last_of_step = 1'b0;
      step_res[step_cnt] = r;
      step_cnt++;
    end
  endfunction

  function automatic void bump_param();
    if (param_num < irclt_pkg::MAX_PARAM_INDEX) param_num++;
  endfunction

  function automatic void hold_char(logic [7:0] b, logic [1:0] kind);
    if (hold_valid) begin
      emit_token(hold_byte, 1'b1, hold_kind, 1'b0, 1'b0);
      token_started = 1'b1;
    end
    hold_byte  = b;
    hold_valid = 1'b1;
    hold_kind  = kind;
  endfunction

  function automatic void close_field(logic [1:0] kind);
    if (hold_valid) emit_token(hold_byte, 1'b1, hold_kind, 1'b1, 1'b0);
    else emit_token(8'd0, 1'b0, kind, 1'b1, 1'b0);
    hold_valid    = 1'b0;
    token_started = 1'b0;
  endfunction

  function automatic logic in_field();
    return tok_phase == irclt_pkg::PH_PREFIX || tok_phase == irclt_pkg::PH_CMD ||
           tok_phase == irclt_pkg::PH_MIDDLE || tok_phase == irclt_pkg::PH_TRAIL;
  endfunction

  function automatic void finish_line();
    if (in_field() && hold_valid) begin
      emit_token(hold_byte, 1'b1, hold_kind, 1'b1, 1'b1);
    end else begin
      case (tok_phase)
        irclt_pkg::PH_PREFIX: emit_token(8'd0, 1'b0, irclt_pkg::KIND_PREFIX, 1'b1, 1'b1);
        irclt_pkg::PH_CMD:    emit_token(8'd0, 1'b0, irclt_pkg::KIND_CMD, 1'b1, 1'b1);
        irclt_pkg::PH_MIDDLE: begin
          if (!token_started && param_num == 0)
            emit_token(8'd0, 1'b0, irclt_pkg::KIND_PREFIX, 1'b0, 1'b1);
          else emit_token(8'd0, 1'b0, irclt_pkg::KIND_MIDDLE, 1'b1, 1'b1);
        end
        irclt_pkg::PH_TRAIL: begin
          if (token_started) emit_token(8'd0, 1'b0, irclt_pkg::KIND_TRAIL, 1'b1, 1'b1);
          else emit_token(8'd0, 1'b0, irclt_pkg::KIND_PREFIX, 1'b0, 1'b1);
        end
        irclt_pkg::PH_PSTART: begin
          if (param_num == 0) emit_token(8'd0, 1'b0, irclt_pkg::KIND_PREFIX, 1'b0, 1'b1);
          else emit_token(8'd0, 1'b0, irclt_pkg::KIND_MIDDLE, 1'b1, 1'b1);
        end
        default: emit_token(8'd0, 1'b0, irclt_pkg::KIND_PREFIX, 1'b0, 1'b1);
      endcase
    end
    tok_phase     = irclt_pkg::PH_START;
    hold_byte     = 8'd0;
    hold_valid    = 1'b0;
    hold_kind     = 2'd0;
    param_num     = '0;
    token_started = 1'b0;
  endfunction

  function automatic void tokenize_byte(logic [7:0] b, logic e);
    step_cnt = 0;
    if (e && b == irclt_pkg::CH_LF && hold_valid && hold_byte == irclt_pkg::CH_CR &&
        in_field()) begin
      hold_valid = 1'b0;
      finish_line();
    end else begin
      case (tok_phase)
        irclt_pkg::PH_PREFIX: begin
          if (b == irclt_pkg::CH_SPACE) begin
            close_field(irclt_pkg::KIND_PREFIX);
            tok_phase = irclt_pkg::PH_CMD;
          end else hold_char(b, irclt_pkg::KIND_PREFIX);
        end
        irclt_pkg::PH_CMD: begin
          if (b == irclt_pkg::CH_SPACE) begin
            close_field(irclt_pkg::KIND_CMD);
            tok_phase = irclt_pkg::PH_PSTART;
          end else hold_char(b, irclt_pkg::KIND_CMD);
        end
        irclt_pkg::PH_PSTART: begin
          if (b == irclt_pkg::CH_SPACE) begin
            emit_token(8'd0, 1'b0, irclt_pkg::KIND_MIDDLE, 1'b1, 1'b0);
            bump_param();
          end else if (b == irclt_pkg::CH_COLON) begin
            tok_phase     = irclt_pkg::PH_TRAIL;
            token_started = 1'b0;
          end else begin
            tok_phase     = irclt_pkg::PH_MIDDLE;
            token_started = 1'b0;
            hold_char(b, irclt_pkg::KIND_MIDDLE);
          end
        end
        irclt_pkg::PH_MIDDLE: begin
          if (b == irclt_pkg::CH_SPACE) begin
            close_field(irclt_pkg::KIND_MIDDLE);
            bump_param();
            tok_phase = irclt_pkg::PH_PSTART;
          end else hold_char(b, irclt_pkg::KIND_MIDDLE);
        end
        irclt_pkg::PH_TRAIL: hold_char(b, irclt_pkg::KIND_TRAIL);
        default: begin
          hold_valid    = 1'b0;
          token_started = 1'b0;
          param_num     = '0;
          if (b == irclt_pkg::CH_COLON) begin
            tok_phase = irclt_pkg::PH_PREFIX;
          end else if (b == irclt_pkg::CH_SPACE) begin
            emit_token(8'd0, 1'b0, irclt_pkg::KIND_CMD, 1'b1, 1'b0);
            tok_phase = irclt_pkg::PH_PSTART;
          end else begin
            tok_phase = irclt_pkg::PH_CMD;
            hold_char(b, irclt_pkg::KIND_CMD);
          end
        end
      endcase
      if (e) finish_line();
    end
    if (step_cnt > 0) step_res[step_cnt-1].last_of_step = 1'b1;
    for (int i = 0; i < step_cnt; i++) expected_tokens = {expected_tokens, step_res[i]};
  endfunction

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    irclt_pkg::res_t got;
    irclt_pkg::res_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) tokenize_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        got.token_byte   = out_tdata[7:0];
        got.param_index  = out_tdata[11:8];
        got.has_byte     = out_tuser[0];
        got.field_kind   = out_tuser[2:1];
        got.token_end    = out_tuser[3];
        got.last_of_step = out_tuser[4];
        got.line_done    = out_tlast;
        results_seen++;
        if (!got.has_byte) markers_seen++;
        if (got.param_index == irclt_pkg::MAX_PARAM_INDEX) saturated_seen++;
        if (expected_tokens.size() == 0) begin
          if (errors < 10)
            $display("%0t: unexpected token result byte=%h has=%b kind=%0d idx=%0d end=%b",
                     $realtime, got.token_byte, got.has_byte, got.field_kind,
                     got.param_index, got.token_end);
          errors++;
        end else begin
          want = expected_tokens.pop_front();
          if (got.token_byte !== want.token_byte || got.has_byte !== want.has_byte ||
              got.field_kind !== want.field_kind || got.param_index !== want.param_index ||
              got.token_end !== want.token_end || got.line_done !== want.line_done ||
              got.last_of_step !== want.last_of_step) begin
            if (errors < 10) begin
              $display("%0t: token mismatch, expected byte=%h has=%b kind=%0d idx=%0d %s",
                       $realtime, want.token_byte, want.has_byte, want.field_kind,
                       want.param_index, "");
              $display("  expected end=%b done=%b last=%b", want.token_end,
                       want.line_done, want.last_of_step);
              $display("  got byte=%h has=%b kind=%0d idx=%0d end=%b done=%b last=%b",
                       got.token_byte, got.has_byte, got.field_kind, got.param_index,
                       got.token_end, got.line_done, got.last_of_step);
            end
            errors++;
          end
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
    if (last) lines_sent++;
    @(negedge clk);
  endtask

  function automatic void append_byte(input logic [7:0] b);
    line_buf = {line_buf, b};
  endfunction

  task automatic send_line();
    for (int i = 0; i < line_buf.size(); i++)
      send_byte(line_buf[i], i == line_buf.size() - 1);
  endtask

  task automatic send_text(input string s);
    line_buf.delete();
    for (int i = 0; i < s.len(); i++) append_byte(s[i]);
    send_line();
  endtask

  function automatic logic [7:0] rand_char(input int special_pct);
    logic [7:0] c;
    c = 8'($urandom_range(255));
    if ($urandom_range(99) < special_pct) begin
      case ($urandom_range(3))
        0: c = irclt_pkg::CH_COLON;
        1: c = irclt_pkg::CH_SPACE;
        2: c = irclt_pkg::CH_CR;
        default: c = irclt_pkg::CH_LF;
      endcase
    end
    return c;
  endfunction

  function automatic logic [7:0] token_char();
    logic [7:0] c;
    do c = rand_char(20); while (c == irclt_pkg::CH_SPACE);
    return c;
  endfunction

  task automatic test_directed();
    send_text(":p C a :t\r\n");
    line_buf.delete();
    append_byte(8'h00);
    send_line();
    line_buf.delete();
    append_byte(irclt_pkg::CH_SPACE);
    append_byte(8'hFF);
    append_byte(irclt_pkg::CH_SPACE);
    append_byte(irclt_pkg::CH_SPACE);
    append_byte(irclt_pkg::CH_COLON);
    send_line();
    send_text(":x");
    send_text("A\r");
    send_text("B\n");
    send_text("C ");
  endtask

  task automatic test_param_saturation();
    line_buf.delete();
    append_byte("P");
    repeat (20) begin
      append_byte(irclt_pkg::CH_SPACE);
      append_byte("q");
    end
    append_byte(irclt_pkg::CH_SPACE);
    append_byte(irclt_pkg::CH_COLON);
    append_byte("z");
    append_byte(irclt_pkg::CH_CR);
    append_byte(irclt_pkg::CH_LF);
    send_line();
    line_buf.delete();
    append_byte("P");
    repeat (18) append_byte(irclt_pkg::CH_SPACE);
    send_line();
  endtask

  task automatic test_wellformed_lines(input int n_items);
    int start;
    int n_par;
    start = bytes_sent;
    while (bytes_sent - start < n_items) begin
      line_buf.delete();
      if ($urandom_range(1)) begin
        append_byte(irclt_pkg::CH_COLON);
        repeat ($urandom_range(4)) append_byte(token_char());
        append_byte(irclt_pkg::CH_SPACE);
      end
      repeat ($urandom_range(1, 5)) append_byte(token_char());
      n_par = ($urandom_range(9) == 0) ? $urandom_range(14, 20) : $urandom_range(4);
      repeat (n_par) begin
        append_byte(irclt_pkg::CH_SPACE);
        if ($urandom_range(7) == 0) append_byte(irclt_pkg::CH_SPACE);
        repeat ($urandom_range(1, 4)) append_byte(token_char());
      end
      if ($urandom_range(2) == 0) begin
        append_byte(irclt_pkg::CH_SPACE);
        append_byte(irclt_pkg::CH_COLON);
        repeat ($urandom_range(6)) append_byte(rand_char(20));
      end
      if ($urandom_range(1)) begin
        append_byte(irclt_pkg::CH_CR);
        append_byte(irclt_pkg::CH_LF);
      end
      send_line();
    end
  endtask

  task automatic test_noise_lines(input int n_items);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < n_items) begin
      line_buf.delete();
      repeat ($urandom_range(1, 12)) append_byte(rand_char(40));
      send_line();
    end
  endtask

  initial begin
    send_idle_pct = 12;
    recv_idle_pct = 63;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_wellformed_lines(430);
    send_idle_pct = 63;
    recv_idle_pct = 12;
    test_param_saturation();
    test_noise_lines(330);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_wellformed_lines(500);
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    errors += expected_tokens.size();
    $display("%0d bytes in %0d lines gave %0d token results (%0d markers, %0d saturated)",
             bytes_sent, lines_sent, results_seen, markers_seen, saturated_seen);
    $display("stall mixes: sender 12/receiver 63, sender 63/receiver 12, none; %0d errors",
             errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results still pending", expected_tokens.size());
    $display("simulation failed");
    $finish;
  end

endmodule
